### hw/rtl/xbcj_pkg.sv
// shared types, constants and tables for the x86 branch filter decoder
// no dependencies
`timescale 1ns / 1ps

package xbcj_pkg;

    localparam int WinLen    = 5;
    localparam int FifoDepth = 8;

    localparam logic [7:0]  OpcodeMask   = 8'hfe;
    localparam logic [7:0]  OpcodeCall   = 8'he8;
    localparam logic [7:0]  ByteAllOnes  = 8'hff;
    localparam logic [31:0] Dest25Mask   = 32'h01ff_ffff;
    localparam logic [31:0] Dest25Sign   = 32'h0100_0000;
    localparam logic [2:0]  DistFar      = 3'd4;
    localparam logic [31:0] ConvStride   = 32'd5;

    // bit i set where mask value i is allowed
    localparam logic [7:0]  MaskAllowed  = 8'b0001_0111;

    function automatic logic [1:0] mask_bitnum(input logic [2:0] m);
        logic [1:0] r;
        case (m)
            3'd0: r = 2'd0;
            3'd1: r = 2'd1;
            3'd2: r = 2'd2;
            3'd3: r = 2'd2;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } xbcj_word_t;

    typedef struct packed {
        logic        start;
        logic [2:0]  mask;
        logic [31:0] src;
        logic [31:0] pos;
    } xbcj_conv_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] dest;
    } xbcj_conv_rsp_t;

endpackage

### hw/rtl/xbcj_conv.sv
// iterative target conversion unit: one subtract and test per cycle
// depends on xbcj_pkg
`timescale 1ns / 1ps

module xbcj_conv (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  xbcj_pkg::xbcj_conv_req_t req,
    output xbcj_pkg::xbcj_conv_rsp_t rsp
);

    logic        busy_reg;
    logic [1:0]  pass_reg;
    logic [2:0]  mask_reg;
    logic [31:0] src_reg;
    logic [31:0] bias_reg;
    logic        done_reg;
    logic [31:0] dest_reg;

    logic [31:0] dest;
    logic [4:0]  sh;
    logic [7:0]  tb;
    logic        stop;

    always_comb begin
        dest = src_reg - bias_reg;
        sh   = {xbcj_pkg::mask_bitnum(mask_reg), 3'b000};
        tb   = 8'(dest >> (5'd24 - sh));
        stop = (mask_reg == 3'd0) || ((tb != 8'h00) && (tb != xbcj_pkg::ByteAllOnes))
               || (pass_reg == 2'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                pass_reg <= 2'd0;
                mask_reg <= req.mask;
                src_reg  <= req.src;
                bias_reg <= req.pos + xbcj_pkg::ConvStride;
            end else if (busy_reg) begin
                if (stop) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    dest_reg <= dest;
                end else begin
                    src_reg  <= dest ^ (32'hffff_ffff >> sh);
                    pass_reg <= pass_reg + 2'd1;
                end
            end
        end
    end

    // keep 25 bits, sign-extend from bit 24
    assign rsp.done = done_reg;
    assign rsp.dest = (dest_reg & xbcj_pkg::Dest25Mask)
                      | ((dest_reg[24]) ? ~xbcj_pkg::Dest25Mask : 32'h0);

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("conversion done without a running pass");
    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pass_reg != 2'd3)
        else $error("correction loop ran past three passes");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("conversion restarted while busy");

endmodule

### hw/rtl/xbcj_front.sv
// front end: takes bytes, keeps the look-ahead window, decides the head byte of each
// full window and pushes decoded words into the queue; depends on xbcj_pkg
`timescale 1ns / 1ps

module xbcj_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     s_tlast,
    output xbcj_pkg::xbcj_word_t     push,
    input  logic                     push_ready,
    output xbcj_pkg::xbcj_conv_req_t conv_req,
    input  xbcj_pkg::xbcj_conv_rsp_t conv_rsp
);

    typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_CONV, S_EMIT} state_t;

    state_t      state_reg;
    logic [7:0]  win_reg [xbcj_pkg::WinLen];
    logic [2:0]  fill_reg;
    logic [31:0] pos_reg;
    logic [2:0]  mask_reg;
    logic [2:0]  dist_reg;
    logic        last_reg;
    logic [2:0]  cnt_reg;
    xbcj_pkg::xbcj_conv_req_t conv_req_reg;

    // head decision
    logic       is_op;
    logic       early;
    logic       do_conv;
    logic [2:0] m_use;
    logic [5:0] m_wide;
    logic [7:0] tbyte;
    logic [2:0] mask_next;
    logic [2:0] dist_next;

    always_comb begin
        is_op     = (win_reg[0] & xbcj_pkg::OpcodeMask) == xbcj_pkg::OpcodeCall;
        early     = 1'b0;
        do_conv   = 1'b0;
        m_use     = 3'd0;
        m_wide    = 6'd0;
        tbyte     = 8'h00;
        mask_next = mask_reg;
        dist_next = dist_reg;
        if (!is_op) begin
            dist_next = (dist_reg < xbcj_pkg::DistFar) ? dist_reg + 3'd1 : xbcj_pkg::DistFar;
        end else begin
            if (dist_reg inside {[3'd1:3'd3]}) begin
                m_wide = {3'b000, mask_reg} << (dist_reg - 3'd1);
                m_use  = m_wide[2:0];
                if (m_use != 3'd0) begin
                    tbyte = win_reg[3'd4 - {1'b0, xbcj_pkg::mask_bitnum(m_use)}];
                    early = !xbcj_pkg::MaskAllowed[m_use] || (tbyte == 8'h00)
                            || (tbyte == xbcj_pkg::ByteAllOnes);
                end
            end
            if (early) begin
                mask_next = {m_use[1:0], 1'b1};
                dist_next = 3'd1;
            end else if ((win_reg[4] == 8'h00) || (win_reg[4] == xbcj_pkg::ByteAllOnes)) begin
                do_conv   = 1'b1;
                mask_next = m_use;
                dist_next = xbcj_pkg::DistFar;
            end else begin
                mask_next = {m_use[1:0], 1'b1};
                dist_next = 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            fill_reg           <= 3'd0;
            pos_reg            <= 32'd0;
            mask_reg           <= 3'd0;
            dist_reg           <= xbcj_pkg::DistFar;
            last_reg           <= 1'b0;
            cnt_reg            <= 3'd0;
            conv_req_reg.start <= 1'b0;
        end else begin
            conv_req_reg.start <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        win_reg[fill_reg] <= s_tdata;
                        fill_reg          <= fill_reg + 3'd1;
                        last_reg          <= s_tlast;
                        if (fill_reg == 3'd4) begin
                            state_reg <= S_DECIDE;
                        end else if (s_tlast) begin
                            cnt_reg   <= fill_reg + 3'd1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_DECIDE: begin
                    mask_reg <= mask_next;
                    dist_reg <= dist_next;
                    if (do_conv) begin
                        conv_req_reg.start <= 1'b1;
                        conv_req_reg.mask  <= m_use;
                        conv_req_reg.src   <= {win_reg[4], win_reg[3], win_reg[2], win_reg[1]};
                        conv_req_reg.pos   <= pos_reg;
                        pos_reg            <= pos_reg + xbcj_pkg::ConvStride;
                        state_reg          <= S_CONV;
                    end else begin
                        pos_reg   <= pos_reg + 32'd1;
                        cnt_reg   <= last_reg ? 3'd5 : 3'd1;
                        state_reg <= S_EMIT;
                    end
                end
                S_CONV: begin
                    if (conv_rsp.done) begin
                        win_reg[1] <= conv_rsp.dest[7:0];
                        win_reg[2] <= conv_rsp.dest[15:8];
                        win_reg[3] <= conv_rsp.dest[23:16];
                        win_reg[4] <= conv_rsp.dest[31:24];
                        cnt_reg    <= 3'd5;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (push_ready) begin
                        for (int i = 0; i < xbcj_pkg::WinLen - 1; i++) begin
                            win_reg[i] <= win_reg[i + 1];
                        end
                        win_reg[xbcj_pkg::WinLen - 1] <= 8'h00;
                        fill_reg <= fill_reg - 3'd1;
                        cnt_reg  <= cnt_reg - 3'd1;
                        if (cnt_reg == 3'd1) begin
                            state_reg <= S_IDLE;
                            if (last_reg) begin
                                fill_reg <= 3'd0;
                                pos_reg  <= 32'd0;
                                mask_reg <= 3'd0;
                                dist_reg <= xbcj_pkg::DistFar;
                                last_reg <= 1'b0;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign push.valid = (state_reg == S_EMIT);
    assign push.data  = win_reg[0];
    assign push.last  = last_reg && (cnt_reg == 3'd1);
    assign conv_req   = conv_req_reg;

    a_decide_full: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DECIDE |-> fill_reg == 3'd5)
        else $error("head decided without a full window");
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> fill_reg <= 3'd4)
        else $error("byte accepted into a full window");
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_rsp.done |-> state_reg == S_CONV)
        else $error("conversion result outside the conversion wait");
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && push_ready && push.last) |=> (fill_reg == 3'd0 && pos_reg == 32'd0))
        else $error("stream state not cleared after the last word");

endmodule

### hw/rtl/xbcj_fifo.sv
// back end: short word queue between the front end and the output channel
// depends on xbcj_pkg
`timescale 1ns / 1ps

module xbcj_fifo #(
    parameter int Depth = xbcj_pkg::FifoDepth
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  xbcj_pkg::xbcj_word_t push,
    output logic                 push_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [8:0]      mem_reg [Depth];
    logic [PtrW-1:0] wr_reg;
    logic [PtrW-1:0] rd_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != CntW'(Depth));
    assign m_tvalid   = (cnt_reg != '0);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = m_tvalid && m_tready;
    assign m_tdata    = mem_reg[rd_reg][8:1];
    assign m_tlast    = mem_reg[rd_reg][0];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= {push.data, push.last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PtrW'(Depth - 1)) ? '0 : wr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PtrW'(Depth - 1)) ? '0 : rd_reg + PtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + CntW'(1);
                2'b01:   cnt_reg <= cnt_reg - CntW'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(Depth))
        else $error("queue count beyond depth");
    a_ptr_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("empty queue with pointers apart");
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> cnt_reg == $past(cnt_reg) - CntW'(1))
        else $error("queue count missed a pop");

endmodule

### hw/rtl/x86_branch_filter_decode.sv
// top level of the x86 branch/call/jump decode filter
// depends on xbcj_pkg, xbcj_conv, xbcj_front and xbcj_fifo
`timescale 1ns / 1ps

// One byte enters per accepted word and decoded bytes leave in stream order, the final
// one of a stream marked by m_tlast. When the window is full the front end decides its
// head byte, and a plain byte is then written to the queue before the next byte is
// taken. An E8/E9 call or jump that is converted runs the correction loop in the
// conversion unit, one 32-bit subtract a pass; the front end waits for the loop, which
// runs at most three passes, and then writes its five bytes into the queue, one per
// cycle while the queue has room, so the byte that completes a converted instruction
// holds the input until all five are written. The front end writes into a queue of
// FIFO_DEPTH words, so the output side may stall without holding it back until the
// queue fills. After the last byte the window is flushed and the next byte starts a
// new stream at position zero.

module x86_branch_filter_decode #(
    parameter int FIFO_DEPTH = xbcj_pkg::FifoDepth
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast
);

    xbcj_pkg::xbcj_word_t     push;
    logic                     push_ready;
    xbcj_pkg::xbcj_conv_req_t conv_req;
    xbcj_pkg::xbcj_conv_rsp_t conv_rsp;

    xbcj_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (conv_req),
        .rsp     (conv_rsp)
    );

    xbcj_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_ready (push_ready),
        .conv_req   (conv_req),
        .conv_rsp   (conv_rsp)
    );

    xbcj_fifo #(
        .Depth (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### tb/x86_branch_filter_decode_tb.sv
// self-checking testbench for the x86 branch/call/jump decode filter
// depends on xbcj_pkg and x86_branch_filter_decode; predicts every decoded word
`timescale 1ns / 1ps

module x86_branch_filter_decode_tb;

    localparam int WatchdogLimit = 4000;
    localparam int TailCycles    = 64;

    // operand byte index table, two bits per mask value
    localparam logic [15:0] OperandSelTab = {2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd0};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dec_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // data_byte[7:0]
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // out_byte[7:0]
    logic       m_tlast;

    logic [7:0]  win [xbcj_pkg::WinLen];
    int          win_fill;
    logic [31:0] stream_pos;
    logic [2:0]  op_mask;
    logic [2:0]  op_dist;

    dec_byte_t pending_bytes[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        idle_cnt = 0;

    x86_branch_filter_decode dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic void clear_window();
        for (int i = 0; i < xbcj_pkg::WinLen; i++) win[i] = 8'h00;
        win_fill   = 0;
        stream_pos = 32'd0;
        op_mask    = 3'd0;
        op_dist    = xbcj_pkg::DistFar;
    endfunction

    function automatic void expect_byte(logic [7:0] b);
        dec_byte_t e;
        e.data = b;
        e.last = 1'b0;
        pending_bytes.push_back(e);
    endfunction

    function automatic void shift_out_head();
        expect_byte(win[0]);
        for (int i = 0; i < xbcj_pkg::WinLen - 1; i++) win[i] = win[i + 1];
        win[xbcj_pkg::WinLen - 1] = 8'h00;
        win_fill   = xbcj_pkg::WinLen - 1;
        stream_pos = stream_pos + 32'd1;
    endfunction

    function automatic void convert_call(logic [2:0] m);
        logic [31:0] src;
        logic [31:0] dest;
        logic [31:0] base;
        logic [31:0] chk;
        int          sh;
        bit          done;
        src  = {win[4], win[3], win[2], win[1]};
        base = stream_pos + xbcj_pkg::ConvStride;
        dest = src - base;
        done = 1'b0;
        for (int pass = 0; pass < 3; pass++) begin
            if (!done) begin
                dest = src - base;
                if (m == 3'd0) begin
                    done = 1'b1;
                end else begin
                    sh  = int'(OperandSelTab[m * 2 +: 2]) * 8;
                    chk = (dest >> (24 - sh)) & 32'h0000_00ff;
                    if (chk != 32'h0 && chk != 32'hff) begin
                        done = 1'b1;
                    end else begin
                        src = dest ^ ((32'd1 << (32 - sh)) - 32'd1);
                    end
                end
            end
        end
        dest = dest & xbcj_pkg::Dest25Mask;
        dest = dest | (32'd0 - (dest & xbcj_pkg::Dest25Sign));
        win[1] = dest[7:0];
        win[2] = dest[15:8];
        win[3] = dest[23:16];
        win[4] = dest[31:24];
        for (int i = 0; i < xbcj_pkg::WinLen; i++) begin
            expect_byte(win[i]);
            win[i] = 8'h00;
        end
        win_fill   = 0;
        stream_pos = stream_pos + xbcj_pkg::ConvStride;
    endfunction

    function automatic void decide_head();
        logic [2:0] m;
        logic [2:0] d;
        logic [7:0] t;
        int         sel;
        m = op_mask;
        d = op_dist;
        if ((win[0] & xbcj_pkg::OpcodeMask) != xbcj_pkg::OpcodeCall) begin
            op_dist = (d < xbcj_pkg::DistFar) ? d + 3'd1 : xbcj_pkg::DistFar;
            shift_out_head();
            return;
        end
        if (d >= 3'd1 && d <= 3'd3) begin
            m = m << (d - 3'd1);
            if (m != 3'd0) begin
                sel = 4 - int'(OperandSelTab[m * 2 +: 2]);
                t   = win[sel];
                if (!xbcj_pkg::MaskAllowed[m] || t == 8'h00 || t == xbcj_pkg::ByteAllOnes) begin
                    op_mask = {m[1:0], 1'b1};
                    op_dist = 3'd1;
                    shift_out_head();
                    return;
                end
            end
        end else begin
            m = 3'd0;
        end
        t = win[4];
        if (t == 8'h00 || t == xbcj_pkg::ByteAllOnes) begin
            op_mask = m;
            op_dist = xbcj_pkg::DistFar;
            convert_call(m);
        end else begin
            op_mask = {m[1:0], 1'b1};
            op_dist = 3'd1;
            shift_out_head();
        end
    endfunction

    function automatic void predict_word(logic [7:0] b, logic l);
        int first;
        first = pending_bytes.size();
        if (win_fill > xbcj_pkg::WinLen - 1) win_fill = xbcj_pkg::WinLen - 1;
        win[win_fill] = b;
        win_fill++;
        if (win_fill == xbcj_pkg::WinLen) decide_head();
        if (l) begin
            for (int i = 0; i < win_fill; i++) expect_byte(win[i]);
            if (pending_bytes.size() > first) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
            clear_window();
        end
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 8'he8;
        if (r < 25) return 8'he9;
        if (r < 40) return 8'h00;
        if (r < 50) return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_word(logic [7:0] b, logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(b, l);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    task automatic send_stream(int len);
        for (int i = 0; i < len; i++) send_word(pick_byte(), i == len - 1);
    endtask

    task automatic test_short_streams();
        send_word(8'h00, 1'b1);
        send_word(8'hff, 1'b0);
        send_word(8'he8, 1'b1);
    endtask

    task automatic test_branch_conversion();
        logic [7:0] seq [21];
        // converted call, converted jump, masked pair, unconverted tail
        seq = '{8'he8, 8'h11, 8'h22, 8'h33, 8'h00,
                8'he9, 8'h44, 8'h55, 8'h66, 8'hff,
                8'he8, 8'h12, 8'he8, 8'h00, 8'h05, 8'h00, 8'hff,
                8'he9, 8'hff, 8'hff, 8'h00};
        for (int i = 0; i < 21; i++) send_word(seq[i], i == 20);
    endtask

    task automatic test_random_streams(int s_pct, int r_pct, int n_items);
        int sent;
        int len;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) len = $urandom_range(4, 1);
            else len = $urandom_range(16, 5);
            send_stream(len);
            sent += len;
        end
    endtask

    task automatic test_drain_pause();
        send_word(8'he8, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        wait_drained();
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        wait_drained();
        send_word(8'h56, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(8'h9a, 1'b1);
    endtask

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        dec_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected word: out_byte %02h out_last %0b",
                                        m_tdata, m_tlast));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data)
                    note_mismatch($sformatf("out_byte: expected %02h, got %02h",
                                            want.data, m_tdata));
                if (m_tlast !== want.last)
                    note_mismatch($sformatf("out_last: expected %0b, got %0b",
                                            want.last, m_tlast));
            end
        end
    end

    // watchdog on stalled handshakes
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WatchdogLimit) begin
            $display("timeout: no word moved for %0d cycles", WatchdogLimit);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        clear_window();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 72;
        test_short_streams();
        test_branch_conversion();
        test_random_streams(22, 72, 25);
        test_random_streams(72, 22, 25);
        test_drain_pause();
        test_random_streams(0, 0, 25);

        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);
        if (pending_bytes.size() != 0)
            note_mismatch($sformatf("%0d words never received", pending_bytes.size()));

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/xbcj_pkg.sv
hw/rtl/xbcj_conv.sv
hw/rtl/xbcj_front.sv
hw/rtl/xbcj_fifo.sv
hw/rtl/x86_branch_filter_decode.sv
tb/x86_branch_filter_decode_tb.sv
